### rtl/core/gpl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpl_pkg
// Shared widths, codes and pipeline payload types of the gradient lookup.
// ----------------------------------------------------------------------------
package gpl_pkg;

    localparam int NUM_STOPS       = 16;
    localparam int SLOT_W          = 4;
    localparam int POS_W           = 17;
    localparam int FRAC_W          = 16;
    localparam int CH_W            = 16;
    localparam int CNT_W           = 5;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = FRAC_W / STEPS_PER_STAGE;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } color_t;

    // Segment result carried alongside the divider
    typedef struct packed {
        logic   hit;
        color_t lo;
        color_t hi;
    } side_t;

    typedef struct packed {
        logic [POS_W-1:0]  rem;
        logic [POS_W-1:0]  den;
        logic [FRAC_W-1:0] quo;
        side_t             side;
    } div_t;

endpackage
`default_nettype wire

### rtl/core/gpl_stops.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpl_stops
// Palette storage and parallel segment search; first pipeline stage.
// ----------------------------------------------------------------------------
module gpl_stops (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      accept,
    input  wire logic                      kind,
    input  wire logic [gpl_pkg::SLOT_W-1:0] stop_slot,
    input  wire logic [gpl_pkg::POS_W-1:0]  stop_position,
    input  wire gpl_pkg::color_t           stop_color,
    input  wire logic [gpl_pkg::FRAC_W-1:0] position,
    input  wire logic [gpl_pkg::CNT_W-1:0]  count,
    output logic                           head_valid,
    output gpl_pkg::div_t                  head
);
    import gpl_pkg::*;

    logic [POS_W-1:0] pos_reg [NUM_STOPS];
    color_t           lo_mem  [NUM_STOPS];
    color_t           hi_mem  [NUM_STOPS];

    logic [CNT_W-1:0]  n_sat;
    logic [POS_W-1:0]  a;
    logic              hit;
    logic [SLOT_W-1:0] k;
    logic [SLOT_W-1:0] k_up;
    logic [POS_W-1:0]  p0;
    logic [POS_W-1:0]  p1;
    logic              is_load;

    assign n_sat   = (count > CNT_W'(NUM_STOPS)) ? CNT_W'(NUM_STOPS) : count;
    assign a       = {1'b0, position};
    assign is_load = accept && (kind == KIND_LOAD);
    assign k_up    = k + SLOT_W'(1);

    // Highest matching segment wins
    always_comb
    begin
        hit = 1'b0;
        k   = '0;
        p0  = '0;
        p1  = '0;
        for (int i = 0; i < NUM_STOPS - 1; i++)
        begin
            if ((CNT_W'(i + 1) < n_sat) && (a >= pos_reg[i]) && (a < pos_reg[i + 1]))
            begin
                hit = 1'b1;
                k   = SLOT_W'(i);
                p0  = pos_reg[i];
                p1  = pos_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            pos_reg[stop_slot] <= stop_position;
            lo_mem[stop_slot]  <= stop_color;
            hi_mem[stop_slot]  <= stop_color;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            head.rem      <= a - p0;
            head.den      <= p1 - p0;
            head.quo      <= '0;
            head.side.hit <= hit;
            head.side.lo  <= lo_mem[k];
            head.side.hi  <= hi_mem[k_up];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            head_valid <= 1'b0;
        else if (adv)
            head_valid <= accept && (kind == KIND_LOOKUP);
    end

endmodule
`default_nettype wire

### rtl/core/gpl_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpl_div
// Pipelined restoring divider for the blend factor, two quotient bits a stage.
// ----------------------------------------------------------------------------
module gpl_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire gpl_pkg::div_t in_item,
    output logic               out_valid,
    output gpl_pkg::div_t      out_item
);
    import gpl_pkg::*;

    div_t stg_reg [DIV_STAGES];
    logic vld_reg [DIV_STAGES];

    function automatic div_t div_step(input div_t d);
        div_t         t;
        logic [POS_W:0] r2;
        t = d;
        for (int s = 0; s < STEPS_PER_STAGE; s++)
        begin
            r2 = {t.rem, 1'b0};
            if (r2 >= {1'b0, t.den})
            begin
                r2    = r2 - {1'b0, t.den};
                t.quo = {t.quo[FRAC_W-2:0], 1'b1};
            end
            else
                t.quo = {t.quo[FRAC_W-2:0], 1'b0};
            t.rem = r2[POS_W-1:0];
        end
        return t;
    endfunction

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        div_t prev;
        logic prev_v;
        if (g == 0)
        begin : g_first
            assign prev   = in_item;
            assign prev_v = in_valid;
        end
        else
        begin : g_rest
            assign prev   = stg_reg[g - 1];
            assign prev_v = vld_reg[g - 1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                stg_reg[g] <= div_step(prev);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (adv)
                vld_reg[g] <= prev_v;
        end
    end

    assign out_item  = stg_reg[DIV_STAGES - 1];
    assign out_valid = vld_reg[DIV_STAGES - 1];

endmodule
`default_nettype wire

### rtl/core/gpl_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpl_mix
// Channel blend lo + (hi - lo) * blend, multiply stage then output register.
// ----------------------------------------------------------------------------
module gpl_mix (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       in_valid,
    input  wire logic [gpl_pkg::FRAC_W-1:0] blend,
    input  wire gpl_pkg::side_t             side,
    output logic                            out_valid,
    output gpl_pkg::color_t                 color,
    output logic                            matched
);
    import gpl_pkg::*;

    localparam int PROD_W = CH_W + FRAC_W + 2;
    localparam int SUM_W  = PROD_W + 1;

    logic signed [PROD_W-1:0] prod_reg [3];
    logic [CH_W-1:0]          lo_reg   [3];
    logic                     hit_reg;
    logic                     vld_reg;

    logic [CH_W-1:0]          lo_ch [3];
    logic [CH_W-1:0]          hi_ch [3];
    logic [CH_W-1:0]          res   [3];

    assign lo_ch[0] = side.lo.r;
    assign lo_ch[1] = side.lo.g;
    assign lo_ch[2] = side.lo.b;
    assign hi_ch[0] = side.hi.r;
    assign hi_ch[1] = side.hi.g;
    assign hi_ch[2] = side.hi.b;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[c] <= PROD_W'(($signed({1'b0, hi_ch[c]}) - $signed({1'b0, lo_ch[c]}))
                               * $signed({1'b0, blend}));
                lo_reg[c]   <= lo_ch[c];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            res[c] = 16'(($signed({1'b0, SUM_W'({lo_reg[c], FRAC_W'(0)})})
                        + SUM_W'(prod_reg[c])) >>> FRAC_W);
        end
    end

    // Output register; drop the color when no segment matched
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            color.r <= hit_reg ? res[0] : '0;
            color.g <= hit_reg ? res[1] : '0;
            color.b <= hit_reg ? res[2] : '0;
            matched <= hit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            hit_reg <= side.hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg   <= in_valid;
            out_valid <= vld_reg;
        end
    end

endmodule
`default_nettype wire

### rtl/core/gradient_palette_lerp.sv
`default_nettype none
// From item accept to result an item passes one search stage, eight divider
// stages (two quotient bits each) and two blend stages.
// Throughput: one item per cycle; the whole pipeline holds while the result stalls.
// Load items write the palette at accept and produce no result.
// Reset clears valid bits and sets stop_count to 2; palette contents stay
// undefined until written.
// ----------------------------------------------------------------------------
// gradient_palette_lerp
// Piecewise linear color gradient: finds the bracketing stop pair for a
// position and blends their colors by a pipelined divide and multiply.
// ----------------------------------------------------------------------------
module gradient_palette_lerp (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item channel
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        kind,
    input  wire logic [3:0]  stop_slot,
    input  wire logic [16:0] stop_position,
    input  wire logic [15:0] stop_red,
    input  wire logic [15:0] stop_green,
    input  wire logic [15:0] stop_blue,
    input  wire logic [15:0] position,
    // result channel
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [15:0]      red,
    output logic [15:0]      green,
    output logic [15:0]      blue,
    output logic             matched,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  stop_count
);
    import gpl_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic             adv;
    logic             accept;
    color_t           stop_color;
    logic             head_valid;
    div_t             head;
    logic             div_valid;
    div_t             div_out;
    color_t           color;

    // Advance every stage unless the result register is full and stalled
    assign adv        = !(result_valid && result_stall);
    assign item_stall = !adv;
    assign accept     = item_valid && adv;
    assign cfg_ready  = 1'b1;

    assign stop_color.r = stop_red;
    assign stop_color.g = stop_green;
    assign stop_color.b = stop_blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= CNT_W'(2);
        else if (cfg_valid && cfg_ready)
            count_reg <= stop_count;
    end

    // Palette and segment search
    gpl_stops u_stops (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .accept       (accept),
        .kind         (kind),
        .stop_slot    (stop_slot),
        .stop_position(stop_position),
        .stop_color   (stop_color),
        .position     (position),
        .count        (count_reg),
        .head_valid   (head_valid),
        .head         (head)
    );

    // Blend factor (a - p0) / (p1 - p0) in Q0.16
    gpl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (head_valid),
        .in_item  (head),
        .out_valid(div_valid),
        .out_item (div_out)
    );

    // Channel blend and output register
    gpl_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (div_valid),
        .blend    (div_out.quo),
        .side     (div_out.side),
        .out_valid(result_valid),
        .color    (color),
        .matched  (matched)
    );

    assign red   = color.r;
    assign green = color.g;
    assign blue  = color.b;

    a_unmatched_zero : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !matched |-> (red == '0) && (green == '0) && (blue == '0))
        else $error("unmatched result carries a color");

    a_cfg_write : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> count_reg == $past(stop_count))
        else $error("stop_count write lost");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(count_reg) || $past(cfg_valid))
        else $error("result dropped while stalled");

endmodule
`default_nettype wire

### tb/sv/gradient_palette_lerp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_palette_lerp_tb
// Drives palette loads and color lookups into the gradient block, predicts
// each interpolated color in a local palette model and checks every result.
// ----------------------------------------------------------------------------
module gradient_palette_lerp_tb;
    import gpl_pkg::*;

    localparam int LATENCY     = 11;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic        kind;
    logic [3:0]  stop_slot;
    logic [16:0] stop_position;
    logic [15:0] stop_red;
    logic [15:0] stop_green;
    logic [15:0] stop_blue;
    logic [15:0] position;
    logic        result_valid;
    logic        result_stall;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        matched;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  stop_count;

    // expected color of one lookup
    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic        hit;
    } shade_t;

    // local copy of the palette and the stop count
    logic [POS_W-1:0] pal_pos [NUM_STOPS];
    color_t           pal_col [NUM_STOPS];
    logic [CNT_W-1:0] used_stops;

    shade_t shade_queue[$];
    int     error_count;
    int     cycle_count;
    bit     hold_off_req;     // request a long receiver hold-off
    bit     hold_off_busy;

    gradient_palette_lerp uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .kind          (kind),
        .stop_slot     (stop_slot),
        .stop_position (stop_position),
        .stop_red      (stop_red),
        .stop_green    (stop_green),
        .stop_blue     (stop_blue),
        .position      (position),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .matched       (matched),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .stop_count    (stop_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length: mostly zero or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Blend one channel between two stop colors.
    function automatic logic [15:0] mix(logic [15:0] lo, logic [15:0] hi,
                                        logic [16:0] blend);
        logic [63:0] acc;
        acc = 64'(lo) * (64'd65536 - 64'(blend)) + 64'(hi) * 64'(blend);
        return acc[31:16];
    endfunction

    // Predict the color of a lookup at position a.
    function automatic shade_t predict_shade(logic [15:0] a);
        shade_t      s;
        int          n;
        int          hit;
        logic [63:0] p0;
        logic [63:0] p1;
        logic [63:0] blend;
        n   = (used_stops > NUM_STOPS) ? NUM_STOPS : int'(used_stops);
        hit = -1;
        s   = '0;
        for (int i = 0; i + 1 < n; i++)
            if (17'(a) >= pal_pos[i] && 17'(a) < pal_pos[i + 1])
                hit = i;
        if (hit >= 0)
        begin
            p0    = 64'(pal_pos[hit]);
            p1    = 64'(pal_pos[hit + 1]);
            blend = ((64'(a) - p0) << 16) / (p1 - p0);
            s.r   = mix(pal_col[hit].r, pal_col[hit + 1].r, blend[16:0]);
            s.g   = mix(pal_col[hit].g, pal_col[hit + 1].g, blend[16:0]);
            s.b   = mix(pal_col[hit].b, pal_col[hit + 1].b, blend[16:0]);
            s.hit = 1'b1;
        end
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Send one item; hold it until accepted, then update the palette model.
    // Valid stays high after the accepting edge so back-to-back items need
    // no drop; a gap or a drain drops it at the next falling edge.
    task automatic send_item(logic k, logic [3:0] slot, logic [16:0] spos,
                             logic [15:0] r, logic [15:0] g, logic [15:0] b,
                             logic [15:0] a);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid    <= 1'b1;
        kind          <= k;
        stop_slot     <= slot;
        stop_position <= spos;
        stop_red      <= r;
        stop_green    <= g;
        stop_blue     <= b;
        position      <= a;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        if (k == KIND_LOAD)
        begin
            pal_pos[slot] = spos;
            pal_col[slot] = '{r: r, g: g, b: b};
        end
        else
            shade_queue.push_back(predict_shade(a));
    endtask

    task automatic load_stop(int slot, logic [16:0] spos, logic [15:0] r,
                             logic [15:0] g, logic [15:0] b);
        send_item(KIND_LOAD, 4'(slot), spos, r, g, b, 16'($urandom()));
    endtask

    task automatic lookup(logic [15:0] a);
        send_item(KIND_LOOKUP, 4'($urandom()), 17'($urandom()), 16'($urandom()),
                  16'($urandom()), 16'($urandom()), a);
    endtask

    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (shade_queue.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Write stop_count while the block is idle.
    task automatic set_stop_count(logic [4:0] n);
        drain();
        cfg_valid  <= 1'b1;
        stop_count <= n;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        used_stops = n;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Load all 16 stops, the first n sorted from 0 up to 1.0, random colors.
    task automatic load_ramp(int n);
        logic [16:0] spos;
        for (int i = 0; i < 16; i++)
        begin
            if (i == 0)
                spos = 17'd0;
            else if (i >= n - 1)
                spos = 17'd65536;
            else
                spos = 17'((65536 / (n - 1)) * i + $urandom_range(0, 300));
            load_stop(i, spos, 16'($urandom()), 16'($urandom()), 16'($urandom()));
        end
    endtask

    // Directed: the field extremes, both kinds, unmatched and overlap cases.
    task automatic test_directed();
        load_stop(0, 17'd0, 16'h0000, 16'hFFFF, 16'h8000);
        load_stop(1, 17'd65536, 16'hFFFF, 16'h0000, 16'h7FFF);
        for (int i = 2; i < 16; i++)
            load_stop(i, 17'd65536, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        lookup(16'h0000);
        lookup(16'hFFFF);
        lookup(16'h8000);
        lookup(16'h0001);
        // stops not increasing: later segment wins
        set_stop_count(5'd4);
        load_stop(1, 17'd16384, 16'h1234, 16'h5678, 16'h9ABC);
        load_stop(2, 17'd8192, 16'hFFFF, 16'h0001, 16'h4000);
        load_stop(3, 17'd65536, 16'h0000, 16'hAAAA, 16'h5555);
        lookup(16'h1000);
        lookup(16'h3000);
        lookup(16'h0000);
        // gap before the first stop: unmatched
        load_stop(0, 17'd100, 16'h1111, 16'h2222, 16'h3333);
        lookup(16'd50);
        // below two stops: every lookup unmatched
        set_stop_count(5'd0);
        lookup(16'h4000);
        set_stop_count(5'd1);
        lookup(16'h0200);
        // above the stop count limit: saturates
        set_stop_count(5'd31);
        lookup(16'hC000);
        set_stop_count(5'd17);
        lookup(16'h2000);
    endtask

    // Random palettes and lookups across several stop counts.
    task automatic test_random();
        int n;
        for (int phase = 0; phase < 6; phase++)
        begin
            n = (phase == 0) ? 2 : (phase == 1) ? 16 : $urandom_range(2, 16);
            set_stop_count(5'(n));
            load_ramp(n);
            for (int j = 0; j < 60; j++)
            begin
                if ($urandom_range(0, 19) == 0)
                    load_stop($urandom_range(0, 15), 17'($urandom_range(0, 65536)),
                              16'($urandom()), 16'($urandom()), 16'($urandom()));
                else
                    lookup(16'($urandom()));
            end
        end
    endtask

    // Long receiver hold-off while items keep coming, then a paused sender.
    task automatic test_backpressure();
        set_stop_count(5'd9);
        load_ramp(9);
        hold_off_req = 1'b1;
        for (int j = 0; j < 40; j++)
            lookup(16'($urandom()));
        hold_off_req = 1'b0;
        drain();
        for (int j = 0; j < 20; j++)
            lookup(16'($urandom()));
    endtask

    // Receiver stall: random gaps, plus a long hold-off when requested.
    initial
    begin
        int gap;
        result_stall  = 1'b1;
        hold_off_busy = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_busy)
            begin
                hold_off_busy = 1'b1;
                result_stall <= 1'b1;
                repeat (60) @(negedge clk);
                result_stall <= 1'b0;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (gap) @(negedge clk);
                end
                result_stall <= 1'b0;
            end
        end
    end

    // Check each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        shade_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (shade_queue.size() == 0)
                report_mismatch("unexpected result", 16'd1, 16'd0);
            else
            begin
                want = shade_queue.pop_front();
                if (red !== want.r)
                    report_mismatch("red", red, want.r);
                if (green !== want.g)
                    report_mismatch("green", green, want.g);
                if (blue !== want.b)
                    report_mismatch("blue", blue, want.b);
                if (matched !== want.hit)
                    report_mismatch("matched", 16'(matched), 16'(want.hit));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        error_count   = 0;
        cycle_count   = 0;
        hold_off_req  = 1'b0;
        used_stops    = 5'd2;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        kind          = KIND_LOOKUP;
        stop_slot     = '0;
        stop_position = '0;
        stop_red      = '0;
        stop_green    = '0;
        stop_blue     = '0;
        position      = '0;
        cfg_valid     = 1'b0;
        stop_count    = 5'd2;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random();
        test_backpressure();
        drain();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
